### src/lrc_pkg.sv
// Shared types and constants of the logistic regression classifier.
// Holds operation codes, the queued command format and the table build helper.
// No dependencies.
`default_nettype none

package lrc_pkg;

  localparam int unsigned IDX_W       = 5;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned SEEN_W      = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam logic [63:0]       Q31_ONE  = 64'd1 << 31;

  typedef enum logic [1:0] {
    OP_WRITE_WEIGHT  = 2'd0,
    OP_WRITE_MEAN    = 2'd1,
    OP_WRITE_INV_DEV = 2'd2,
    OP_SAMPLE        = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_INTERCEPT,
    CMD_WEIGHT,
    CMD_MEAN,
    CMD_INV_DEV,
    CMD_SAMPLE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic [IDX_W-1:0]          index;
    logic signed [DATA_W-1:0]  value;
    logic                      last;
  } cmd_t;

  // Raises a Q1.31 exponential to the power 4096 by twelve rounded squarings.
  function automatic logic [63:0] sig_square12(input logic [63:0] e_in);
    logic [63:0] e;
    e = e_in;
    for (int k = 0; k < 12; k++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

### src/lrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lrc_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/lrc_front.sv
// Front end: accepts input transfers, checks table indexes and classifies items.
// Depends on lrc_pkg.
`default_nettype none

module lrc_front import lrc_pkg::*; #(
  parameter int unsigned FEATURE_COUNT = 16
) (
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic [IDX_W-1:0]         table_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_feature_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  localparam logic [8:0] FC_LIMIT = 9'(FEATURE_COUNT);

  logic [8:0] idx_ext;
  logic       weight_ok;
  logic       feature_ok;
  logic       keep;

  assign idx_ext    = 9'(table_index_i);
  assign weight_ok  = idx_ext <= FC_LIMIT;
  assign feature_ok = (table_index_i != '0) && (idx_ext <= FC_LIMIT);

  always_comb begin
    cmd_o.kind  = CMD_SAMPLE;
    cmd_o.index = table_index_i;
    cmd_o.value = value_i;
    cmd_o.last  = 1'b0;
    keep        = 1'b0;
    case (op_e'(operation_i))
      OP_WRITE_WEIGHT: begin
        cmd_o.kind = (table_index_i == '0) ? CMD_INTERCEPT : CMD_WEIGHT;
        keep       = weight_ok;
      end
      OP_WRITE_MEAN: begin
        cmd_o.kind = CMD_MEAN;
        keep       = feature_ok;
      end
      OP_WRITE_INV_DEV: begin
        cmd_o.kind = CMD_INV_DEV;
        keep       = feature_ok;
      end
      OP_SAMPLE: begin
        cmd_o.kind = CMD_SAMPLE;
        cmd_o.last = last_feature_i;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

### src/lrc_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on lrc_pkg.
`default_nettype none

module lrc_queue import lrc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic not_empty_o,
  output cmd_t cmd_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
  assign rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
  assign count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o      = count_q == CNT_W'(QUEUE_DEPTH);
  assign not_empty_o = count_q != '0;
  assign cmd_o       = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

### src/lrc_back.sv
// Back end: table writes, normalize-multiply-accumulate pipeline and sigmoid lookup.
// Depends on lrc_pkg and lrc_ram.
`default_nettype none

module lrc_back import lrc_pkg::*; #(
  parameter int unsigned FEATURE_COUNT      = 16,
  parameter int unsigned SIGMOID_TABLE_SIZE = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       probability_o,
  output logic              class_label_o,
  output logic              saturated_o,
  output logic [SEEN_W-1:0] features_seen_o
);

  localparam int unsigned ADDR_W    = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int unsigned POS_W     = $clog2(FEATURE_COUNT + 1);
  localparam int unsigned SIG_IDX_W = $clog2(SIGMOID_TABLE_SIZE);
  localparam int unsigned SIZE_W    = $clog2(SIGMOID_TABLE_SIZE + 1);

  localparam logic [POS_W-1:0]     POS_LIMIT = POS_W'(FEATURE_COUNT);
  localparam logic [SIZE_W-1:0]    SIG_SIZE  = SIZE_W'(SIGMOID_TABLE_SIZE);
  localparam logic [SIG_IDX_W-1:0] SIG_LAST  = SIG_IDX_W'(SIGMOID_TABLE_SIZE - 1);

  // Sigmoid table, built at elaboration.
  logic [15:0] sig_rom [SIGMOID_TABLE_SIZE];

  for (genvar gi = 0; gi < SIGMOID_TABLE_SIZE; gi++) begin : g_sig
    localparam longint      NUM = 16 * longint'(gi) - 8 * longint'(SIGMOID_TABLE_SIZE);
    localparam logic [63:0] MAG = (NUM < 0) ? 64'(-NUM) : 64'(NUM);
    localparam logic [63:0] DEN = 64'(SIGMOID_TABLE_SIZE) * 64'd4096;
    localparam logic [63:0] U1  = ((MAG << 31) + DEN / 64'd2) / DEN;
    localparam logic [63:0] U2  = (U1 * U1) >> 31;
    localparam logic [63:0] U3  = (U2 * U1) >> 31;
    localparam logic [63:0] E0  = Q31_ONE - U1 + U2 / 64'd2 - U3 / 64'd6;
    localparam logic [63:0] EX  = sig_square12(E0);
    localparam logic [63:0] DV  = Q31_ONE + EX;
    localparam logic [63:0] PR  = (NUM >= 0) ? ((64'd1 << 47) + DV / 64'd2) / DV
                                             : ((EX << 16) + DV / 64'd2) / DV;
    assign sig_rom[gi] = (PR > 64'd65535) ? 16'hFFFF : PR[15:0];
  end

  logic adv;
  logic is_sample;
  logic acc_en;
  logic [POS_W-1:0] count_next;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [SEEN_W-1:0] seen_next;
  logic [IDX_W-1:0] idx_m1;
  logic [ADDR_W+IDX_W-1:0] waddr_wide;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic ram_re;
  logic [15:0] weight_rdata, mean_rdata, inv_rdata;
  logic signed [15:0] intercept_q;

  assign adv       = !out_valid_o || !out_stall_i;
  assign pop_o     = q_valid_i && adv;
  assign is_sample = pop_o && (cmd_i.kind == CMD_SAMPLE);
  assign acc_en    = pos_q < POS_LIMIT;
  assign count_next = acc_en ? pos_q + POS_W'(1) : pos_q;
  assign seen_next = (32'(count_next) > 32'(SEEN_MAX)) ? SEEN_MAX : SEEN_W'(count_next);
  assign pos_d     = is_sample ? (cmd_i.last ? '0 : count_next) : pos_q;

  assign idx_m1     = cmd_i.index - IDX_W'(1);
  assign waddr_wide = {{ADDR_W{1'b0}}, idx_m1};
  assign waddr      = waddr_wide[ADDR_W-1:0];
  assign raddr      = pos_q[ADDR_W-1:0];
  assign ram_re     = is_sample && acc_en;

  lrc_ram #(.WIDTH(16), .DEPTH(FEATURE_COUNT)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (pop_o && (cmd_i.kind == CMD_WEIGHT)),
    .waddr_i (waddr),
    .wdata_i (cmd_i.value),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (weight_rdata)
  );

  lrc_ram #(.WIDTH(16), .DEPTH(FEATURE_COUNT)) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (pop_o && (cmd_i.kind == CMD_MEAN)),
    .waddr_i (waddr),
    .wdata_i (cmd_i.value),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (mean_rdata)
  );

  lrc_ram #(.WIDTH(16), .DEPTH(FEATURE_COUNT)) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (pop_o && (cmd_i.kind == CMD_INV_DEV)),
    .waddr_i (waddr),
    .wdata_i (cmd_i.value),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (inv_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o && (cmd_i.kind == CMD_INTERCEPT)) begin
      intercept_q <= cmd_i.value;
    end
  end

  // Stage 1: table words arrive from the RAMs.
  logic s1_valid_q, s1_acc_en_q, s1_first_q, s1_last_q;
  logic [SEEN_W-1:0] s1_seen_q;
  logic signed [15:0] s1_value_q, s1_intercept_q;
  logic signed [16:0] s1_diff;
  logic signed [15:0] inv_s;
  logic signed [32:0] s1_prod;

  assign inv_s   = inv_rdata;
  assign s1_diff = {s1_value_q[15], s1_value_q} - {mean_rdata[15], mean_rdata};
  assign s1_prod = s1_diff * inv_s;

  // Stage 2: round the normalized feature and weight it.
  logic s2_valid_q, s2_acc_en_q, s2_first_q, s2_last_q;
  logic [SEEN_W-1:0] s2_seen_q;
  logic signed [15:0] s2_intercept_q, s2_weight_q;
  logic signed [32:0] s2_prod_q;
  logic [33:0] s2_rnd;
  logic signed [25:0] s2_z;
  logic signed [41:0] s2_term;

  assign s2_rnd  = {s2_prod_q[32], s2_prod_q} + 34'd128;
  assign s2_z    = s2_rnd[33:8];
  assign s2_term = s2_z * s2_weight_q;

  // Stage 3: saturating accumulate.
  logic s3_valid_q, s3_acc_en_q, s3_first_q, s3_last_q;
  logic [SEEN_W-1:0] s3_seen_q;
  logic signed [15:0] s3_intercept_q;
  logic signed [41:0] s3_term_q;
  logic [42:0] base, sum;
  logic ovf_hi, ovf_lo;
  logic [39:0] acc_sat;
  logic signed [39:0] acc_q, acc_d;
  logic clip_q, clip_d;

  assign base = s3_first_q ? {{19{s3_intercept_q[15]}}, s3_intercept_q, 8'd0}
                           : {{3{acc_q[39]}}, acc_q};
  assign sum     = base + {s3_term_q[41], s3_term_q};
  assign ovf_hi  = !sum[42] && (sum[41:39] != 3'b000);
  assign ovf_lo  = sum[42] && (sum[41:39] != 3'b111);
  assign acc_sat = ovf_hi ? {1'b0, {39{1'b1}}} : (ovf_lo ? {1'b1, {39{1'b0}}} : sum[39:0]);

  always_comb begin
    acc_d  = acc_q;
    clip_d = clip_q;
    if (adv && s3_valid_q && s3_acc_en_q) begin
      acc_d  = acc_sat;
      clip_d = (s3_first_q ? 1'b0 : clip_q) | ovf_hi | ovf_lo;
    end
  end

  // Stage 4: sigmoid table index from the finished sum.
  logic s4_valid_q;
  logic [SEEN_W-1:0] s4_seen_q;
  logic sel_lo, sel_hi;
  logic [23:0] offset;
  logic [23+SIZE_W:0] idx_prod;
  logic [SIG_IDX_W-1:0] idx_next;

  assign sel_lo   = acc_q < -40'sd8388608;
  assign sel_hi   = acc_q >= 40'sd8388608;
  assign offset   = {~acc_q[23], acc_q[22:0]};
  assign idx_prod = {{SIZE_W{1'b0}}, offset} * {24'd0, SIG_SIZE};
  assign idx_next = sel_lo ? '0 : (sel_hi ? SIG_LAST : idx_prod[24 +: SIG_IDX_W]);

  // Stage 5: table read into the output register.
  logic s5_valid_q, s5_clip_q;
  logic [SEEN_W-1:0] s5_seen_q;
  logic [SIG_IDX_W-1:0] s5_idx_q;
  logic out_valid_q;
  logic [15:0] prob_q;
  logic sat_q;
  logic [SEEN_W-1:0] seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      clip_q <= clip_d;
      if (adv) begin
        s1_valid_q  <= is_sample;
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        s4_valid_q  <= s3_valid_q && s3_last_q;
        s5_valid_q  <= s4_valid_q;
        out_valid_q <= s5_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_acc_en_q    <= acc_en;
      s1_first_q     <= pos_q == '0;
      s1_last_q      <= cmd_i.last;
      s1_seen_q      <= seen_next;
      s1_value_q     <= cmd_i.value;
      s1_intercept_q <= intercept_q;

      s2_acc_en_q    <= s1_acc_en_q;
      s2_first_q     <= s1_first_q;
      s2_last_q      <= s1_last_q;
      s2_seen_q      <= s1_seen_q;
      s2_intercept_q <= s1_intercept_q;
      s2_prod_q      <= s1_prod;
      s2_weight_q    <= weight_rdata;

      s3_acc_en_q    <= s2_acc_en_q;
      s3_first_q     <= s2_first_q;
      s3_last_q      <= s2_last_q;
      s3_seen_q      <= s2_seen_q;
      s3_intercept_q <= s2_intercept_q;
      s3_term_q      <= s2_term;

      s4_seen_q <= s3_seen_q;

      s5_idx_q  <= idx_next;
      s5_clip_q <= clip_q;
      s5_seen_q <= s4_seen_q;

      if (s5_valid_q) begin
        prob_q <= sig_rom[s5_idx_q];
        sat_q  <= s5_clip_q;
        seen_q <= s5_seen_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign probability_o   = prob_q;
  assign class_label_o   = prob_q[15];
  assign saturated_o     = sat_q;
  assign features_seen_o = seen_q;

endmodule

`default_nettype wire

### src/logistic_regression_classifier_unit.sv
// Top level of the logistic regression classifier.
// Depends on lrc_pkg, lrc_front, lrc_queue and lrc_back.
//
// Each input transfer either writes one word of the weight, mean or inverse
// deviation tables or brings the next feature of the current case; the
// feature marked last produces one result transfer with the sigmoid
// probability, the class label, the clip flag and the feature count. The
// block takes one item per clock cycle while the queue is not full. The result
// of the last feature passes the two-entry queue, the RAM read, the normalize
// and weight multiplies, the 40-bit saturating accumulator and the sigmoid
// table index and read. The accumulator add and the feature position count
// are the only recurrences, so the rate is set by the back-end pipeline, which
// holds as a whole while a finished result is stalled on the output.
`default_nettype none

module logistic_regression_classifier_unit import lrc_pkg::*; #(
  parameter int unsigned FEATURE_COUNT      = 16,
  parameter int unsigned SIGMOID_TABLE_SIZE = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic [IDX_W-1:0]         table_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_feature_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [15:0]              probability_o,
  output logic                     class_label_o,
  output logic                     saturated_o,
  output logic [SEEN_W-1:0]        features_seen_o
);

  logic push;
  logic q_full;
  logic q_not_empty;
  logic pop;
  cmd_t front_cmd;
  cmd_t queue_cmd;

  lrc_front #(.FEATURE_COUNT(FEATURE_COUNT)) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .table_index_i  (table_index_i),
    .value_i        (value_i),
    .last_feature_i (last_feature_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (front_cmd)
  );

  lrc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (front_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .cmd_o       (queue_cmd)
  );

  lrc_back #(
    .FEATURE_COUNT      (FEATURE_COUNT),
    .SIGMOID_TABLE_SIZE (SIGMOID_TABLE_SIZE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_not_empty),
    .cmd_i           (queue_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .probability_o   (probability_o),
    .class_label_o   (class_label_o),
    .saturated_o     (saturated_o),
    .features_seen_o (features_seen_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("Command pushed into a full queue.");

  a_seen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (features_seen_o != '0))
    else $error("Result transfer with no accumulated feature.");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(features_seen_o) <= FEATURE_COUNT))
    else $error("Feature count exceeds the configured feature count.");

  a_label_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (class_label_o == probability_o[15]))
    else $error("Class label disagrees with the probability.");

endmodule

`default_nettype wire
